@@ sv/tcs_pkg.sv @@
package tcs_pkg;

	localparam int COORD_BITS = 24;
	localparam int CS_W = 17;
	localparam int CFG_IDX_W = 3;
	localparam int COS_ONE_SH = 16;

	localparam int STRAY_H_LIMIT = 600 * 256;
	localparam int STRAY_XZ_LIMIT = 3500 * 256;
	localparam int SEABED_H = -384;
	localparam int EXT_W = ((COORD_BITS > 22) ? COORD_BITS : 22) + 1;

	localparam int DW = COORD_BITS + 1;
	localparam int PW = 2 * DW;
	localparam int NW = PW + 1;
	localparam int LO_W = (NW + 1) / 2;
	localparam int HI_W = NW - LO_W;
	localparam int HH_W = 2 * HI_W;
	localparam int HL_W = HI_W + LO_W;
	localparam int LL_W = 2 * LO_W;
	localparam int SQ_W = 2 * NW;
	localparam int L2_W = SQ_W + 2;
	localparam int CH_W = (L2_W + 3) / 4;
	localparam int L2P_W = 4 * CH_W;
	localparam int PT_W = CS_W + CH_W;
	localparam int CMP_W = L2_W + CS_W;

	localparam int Q_DEPTH = 4;
	localparam int Q_AW = $clog2(Q_DEPTH);
	localparam int Q_CW = $clog2(Q_DEPTH + 1);
	localparam int OUT_DEPTH = 16;
	localparam int OUT_AW = $clog2(OUT_DEPTH);
	localparam int OUT_CW = $clog2(OUT_DEPTH + 1);

	typedef logic signed [COORD_BITS-1:0] coord_t;
	typedef logic signed [DW-1:0] diff_t;

	typedef enum logic [1:0] {
		VERDICT_KEPT    = 2'd0,
		VERDICT_OUTSIDE = 2'd1,
		VERDICT_STRAY   = 2'd2,
		VERDICT_SEABED  = 2'd3
	} verdict_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_TILE_MIN_X   = 3'd0,
		CFG_TILE_MAX_X   = 3'd1,
		CFG_TILE_MIN_H   = 3'd2,
		CFG_TILE_MAX_H   = 3'd3,
		CFG_TILE_MIN_Z   = 3'd4,
		CFG_TILE_MAX_Z   = 3'd5,
		CFG_SLOPE_COS_SQ = 3'd6
	} cfg_reg_t;

	typedef struct packed {
		coord_t min_x;
		coord_t max_x;
		coord_t min_h;
		coord_t max_h;
		coord_t min_z;
		coord_t max_z;
	} tcs_box_t;

	typedef struct packed {
		verdict_t verdict;
		diff_t ux;
		diff_t uy;
		diff_t uz;
		diff_t vx;
		diff_t vy;
		diff_t vz;
	} tcs_item_t;

	typedef struct packed {
		verdict_t verdict;
		logic walkable;
	} tcs_res_t;

endpackage

@@ sv/tcs_front.sv @@
module tcs_front import tcs_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  tcs_box_t  box,
	input  logic      push,
	output logic      full,
	input  coord_t    a_x,
	input  coord_t    a_h,
	input  coord_t    a_z,
	input  coord_t    b_x,
	input  coord_t    b_h,
	input  coord_t    b_z,
	input  coord_t    c_x,
	input  coord_t    c_h,
	input  coord_t    c_z,
	input  logic      q_full,
	output logic      q_push,
	output tcs_item_t q_item
);

	localparam logic signed [EXT_W-1:0] H_LIM = EXT_W'(STRAY_H_LIMIT);
	localparam logic signed [EXT_W-1:0] XZ_LIM = EXT_W'(STRAY_XZ_LIMIT);
	localparam logic signed [EXT_W-1:0] XZ_LIM_N = EXT_W'(-STRAY_XZ_LIMIT);
	localparam logic signed [EXT_W-1:0] SEA_LIM = EXT_W'(SEABED_H);

	function automatic coord_t min3(coord_t p, coord_t q, coord_t r);
		coord_t m;
		m = p;
		if (q < m) m = q;
		if (r < m) m = r;
		return m;
	endfunction

	function automatic coord_t max3(coord_t p, coord_t q, coord_t r);
		coord_t m;
		m = p;
		if (q > m) m = q;
		if (r > m) m = r;
		return m;
	endfunction

	function automatic logic far_xz(coord_t c);
		logic signed [EXT_W-1:0] e;
		e = EXT_W'(c);
		return (e > XZ_LIM) || (e < XZ_LIM_N);
	endfunction

	function automatic logic high_h(coord_t c);
		logic signed [EXT_W-1:0] e;
		e = EXT_W'(c);
		return e > H_LIM;
	endfunction

	function automatic logic low_h(coord_t c);
		logic signed [EXT_W-1:0] e;
		e = EXT_W'(c);
		return e < SEA_LIM;
	endfunction

	logic      outside;
	logic      stray;
	logic      seabed;
	logic      accept;
	tcs_item_t item_d;
	tcs_item_t item_s1;
	logic      vld_s1;

	always_comb begin
		outside = (max3(a_x, b_x, c_x) < box.min_x) || (min3(a_x, b_x, c_x) > box.max_x) ||
			(max3(a_h, b_h, c_h) < box.min_h) || (min3(a_h, b_h, c_h) > box.max_h) ||
			(max3(a_z, b_z, c_z) < box.min_z) || (min3(a_z, b_z, c_z) > box.max_z);
		stray = high_h(a_h) || high_h(b_h) || high_h(c_h) ||
			far_xz(a_x) || far_xz(b_x) || far_xz(c_x) ||
			far_xz(a_z) || far_xz(b_z) || far_xz(c_z);
		seabed = low_h(a_h) && low_h(b_h) && low_h(c_h);
		if (outside) begin
			item_d.verdict = VERDICT_OUTSIDE;
		end else if (stray) begin
			item_d.verdict = VERDICT_STRAY;
		end else if (seabed) begin
			item_d.verdict = VERDICT_SEABED;
		end else begin
			item_d.verdict = VERDICT_KEPT;
		end
		item_d.ux = DW'(b_x) - DW'(a_x);
		item_d.uy = DW'(b_h) - DW'(a_h);
		item_d.uz = DW'(b_z) - DW'(a_z);
		item_d.vx = DW'(c_x) - DW'(a_x);
		item_d.vy = DW'(c_h) - DW'(a_h);
		item_d.vz = DW'(c_z) - DW'(a_z);
	end

	assign full   = vld_s1 && q_full;
	assign accept = push && !full;
	assign q_push = vld_s1 && !q_full;
	assign q_item = item_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= accept || (vld_s1 && q_full);
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1 <= item_d;
		end
	end

endmodule

@@ sv/tcs_queue.sv @@
module tcs_queue import tcs_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      push,
	input  tcs_item_t item_in,
	output logic      full,
	input  logic      pop,
	output logic      empty,
	output tcs_item_t item_out
);

	tcs_item_t         mem_q [Q_DEPTH];
	logic [Q_AW-1:0]   wr_q;
	logic [Q_AW-1:0]   rd_q;
	logic [Q_CW-1:0]   cnt_q;

	assign full     = cnt_q == Q_CW'(Q_DEPTH);
	assign empty    = cnt_q == '0;
	assign item_out = mem_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wr_q <= wr_q + 1'b1;
			if (pop) rd_q <= rd_q + 1'b1;
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= item_in;
		end
	end

endmodule

@@ sv/tcs_back.sv @@
module tcs_back import tcs_pkg::*; (
	input  logic            clk,
	input  logic            arst_n,
	input  logic [CS_W-1:0] cs,
	input  logic            q_empty,
	input  tcs_item_t       q_item,
	output logic            q_pop,
	input  logic            pop,
	output logic            empty,
	output tcs_res_t        res
);

	logic [OUT_CW-1:0] track_q;
	logic              res_pop;

	logic              vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6, vld_s7, vld_s8, vld_s9;
	verdict_t          vrd_s1, vrd_s2, vrd_s3, vrd_s4, vrd_s5, vrd_s6, vrd_s7, vrd_s8, vrd_s9;

	logic signed [PW-1:0] prod_s1 [6];
	logic signed [NW-1:0] n_s2 [3];
	logic [NW-1:0]        mag_s3 [3];
	logic [HH_W-1:0]      hh_s4 [3];
	logic [HL_W-1:0]      hl_s4 [3];
	logic [LL_W-1:0]      ll_s4 [3];
	logic [SQ_W-1:0]      sq_s5 [3];
	logic [L2_W-1:0]      len2_s6;
	logic [SQ_W-1:0]      sy_s6, sy_s7, sy_s8, sy_s9;
	logic [PT_W-1:0]      part_s7 [4];
	logic                 nz_s7, nz_s8, nz_s9;
	logic [CMP_W-1:0]     rlo_s8, rhi_s8, rhs_s9;
	logic [L2P_W-1:0]     len2_pad;
	logic [CMP_W-1:0]     lhs;
	tcs_res_t             res_d;

	tcs_res_t             mem_q [OUT_DEPTH];
	logic [OUT_AW-1:0]    wr_q;
	logic [OUT_AW-1:0]    rd_q;
	logic [OUT_CW-1:0]    cnt_q;

	assign q_pop   = !q_empty && (track_q < OUT_CW'(OUT_DEPTH));
	assign empty   = cnt_q == '0;
	assign res_pop = pop && !empty;
	assign res     = mem_q[rd_q];

	assign len2_pad = L2P_W'(len2_s6);
	assign lhs      = CMP_W'(sy_s9) << COS_ONE_SH;

	always_comb begin
		res_d.verdict  = vrd_s9;
		res_d.walkable = (vrd_s9 == VERDICT_KEPT) && nz_s9 && (lhs >= rhs_s9);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			track_q <= '0;
			vld_s1  <= 1'b0;
			vld_s2  <= 1'b0;
			vld_s3  <= 1'b0;
			vld_s4  <= 1'b0;
			vld_s5  <= 1'b0;
			vld_s6  <= 1'b0;
			vld_s7  <= 1'b0;
			vld_s8  <= 1'b0;
			vld_s9  <= 1'b0;
			wr_q    <= '0;
			rd_q    <= '0;
			cnt_q   <= '0;
		end else begin
			if (q_pop && !res_pop) begin
				track_q <= track_q + 1'b1;
			end else if (res_pop && !q_pop) begin
				track_q <= track_q - 1'b1;
			end
			vld_s1 <= q_pop;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
			vld_s6 <= vld_s5;
			vld_s7 <= vld_s6;
			vld_s8 <= vld_s7;
			vld_s9 <= vld_s8;
			if (vld_s9) wr_q <= wr_q + 1'b1;
			if (res_pop) rd_q <= rd_q + 1'b1;
			if (vld_s9 && !res_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (res_pop && !vld_s9) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		vrd_s1 <= q_item.verdict;
		vrd_s2 <= vrd_s1;
		vrd_s3 <= vrd_s2;
		vrd_s4 <= vrd_s3;
		vrd_s5 <= vrd_s4;
		vrd_s6 <= vrd_s5;
		vrd_s7 <= vrd_s6;
		vrd_s8 <= vrd_s7;
		vrd_s9 <= vrd_s8;

		prod_s1[0] <= PW'(q_item.uy) * PW'(q_item.vz);
		prod_s1[1] <= PW'(q_item.uz) * PW'(q_item.vy);
		prod_s1[2] <= PW'(q_item.uz) * PW'(q_item.vx);
		prod_s1[3] <= PW'(q_item.ux) * PW'(q_item.vz);
		prod_s1[4] <= PW'(q_item.ux) * PW'(q_item.vy);
		prod_s1[5] <= PW'(q_item.uy) * PW'(q_item.vx);

		for (int k = 0; k < 3; k++) begin
			n_s2[k]   <= NW'(prod_s1[2*k]) - NW'(prod_s1[2*k+1]);
			mag_s3[k] <= $unsigned(n_s2[k][NW-1] ? -n_s2[k] : n_s2[k]);
			hh_s4[k]  <= HH_W'(mag_s3[k][NW-1:LO_W]) * HH_W'(mag_s3[k][NW-1:LO_W]);
			hl_s4[k]  <= HL_W'(mag_s3[k][NW-1:LO_W]) * HL_W'(mag_s3[k][LO_W-1:0]);
			ll_s4[k]  <= LL_W'(mag_s3[k][LO_W-1:0]) * LL_W'(mag_s3[k][LO_W-1:0]);
			sq_s5[k]  <= (SQ_W'(hh_s4[k]) << (2 * LO_W)) + (SQ_W'(hl_s4[k]) << (LO_W + 1)) +
				SQ_W'(ll_s4[k]);
		end

		len2_s6 <= L2_W'(sq_s5[0]) + L2_W'(sq_s5[1]) + L2_W'(sq_s5[2]);
		sy_s6   <= sq_s5[1];

		for (int i = 0; i < 4; i++) begin
			part_s7[i] <= PT_W'(cs) * PT_W'(len2_pad[i*CH_W +: CH_W]);
		end
		nz_s7 <= |len2_s6;
		sy_s7 <= sy_s6;

		rlo_s8 <= CMP_W'(part_s7[0]) + (CMP_W'(part_s7[1]) << CH_W);
		rhi_s8 <= (CMP_W'(part_s7[2]) << (2 * CH_W)) + (CMP_W'(part_s7[3]) << (3 * CH_W));
		nz_s8  <= nz_s7;
		sy_s8  <= sy_s7;

		rhs_s9 <= rlo_s8 + rhi_s8;
		nz_s9  <= nz_s8;
		sy_s9  <= sy_s8;

		if (vld_s9) begin
			mem_q[wr_q] <= res_d;
		end
	end

endmodule

@@ sv/triangle_cull_and_slope_classifier.sv @@
// Triangle cull and slope classifier: one triangle in, one verdict out.
// Input channel: drive a_*, b_*, c_* (signed Q.8 coordinates, h is up) and
// raise push; the transaction completes at a clock edge where push is high
// and full is low. Result channel: while empty is low, verdict and walkable
// show the oldest result; raise pop to take it. Results leave in input order.
// Configuration: write tile box bounds and slope_cos_sq through cfg_valid,
// cfg_index, cfg_data; cfg_ready is always high. Write only while idle.
// An accepted triangle passes the front register, the middle queue, the slope
// pipeline and the result queue. One triangle per cycle while full is low; the
// nine-stage pipeline takes one item per cycle while the result queue has room.
// The front classifies and registers each triangle into a 4-entry queue; the
// back issues from that queue only while the 16-entry result queue has room
// for everything in flight, so a stalled receiver first fills the result
// queue, then the middle queue, then raises full.
// Reset clears all queues, the pipeline valid bits and every configuration
// register to zero; the block accepts triangles in the first cycle after it.
module triangle_cull_and_slope_classifier import tcs_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [COORD_BITS-1:0] cfg_data,
	input  logic                 push,
	output logic                 full,
	input  coord_t               a_x,
	input  coord_t               a_h,
	input  coord_t               a_z,
	input  coord_t               b_x,
	input  coord_t               b_h,
	input  coord_t               b_z,
	input  coord_t               c_x,
	input  coord_t               c_h,
	input  coord_t               c_z,
	output logic                 empty,
	input  logic                 pop,
	output logic [1:0]           verdict,
	output logic                 walkable
);

	tcs_box_t        box_q;
	logic [CS_W-1:0] slope_cos_sq_q;

	logic      q_push;
	logic      q_full;
	logic      q_pop;
	logic      q_empty;
	tcs_item_t q_in;
	tcs_item_t q_out;
	tcs_res_t  res;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			box_q          <= '0;
			slope_cos_sq_q <= '0;
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_TILE_MIN_X:   box_q.min_x <= cfg_data;
				CFG_TILE_MAX_X:   box_q.max_x <= cfg_data;
				CFG_TILE_MIN_H:   box_q.min_h <= cfg_data;
				CFG_TILE_MAX_H:   box_q.max_h <= cfg_data;
				CFG_TILE_MIN_Z:   box_q.min_z <= cfg_data;
				CFG_TILE_MAX_Z:   box_q.max_z <= cfg_data;
				CFG_SLOPE_COS_SQ: slope_cos_sq_q <= cfg_data[CS_W-1:0];
				default: ;
			endcase
		end
	end

	tcs_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.box    (box_q),
		.push   (push),
		.full   (full),
		.a_x    (a_x),
		.a_h    (a_h),
		.a_z    (a_z),
		.b_x    (b_x),
		.b_h    (b_h),
		.b_z    (b_z),
		.c_x    (c_x),
		.c_h    (c_h),
		.c_z    (c_z),
		.q_full (q_full),
		.q_push (q_push),
		.q_item (q_in)
	);

	tcs_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.item_in  (q_in),
		.full     (q_full),
		.pop      (q_pop),
		.empty    (q_empty),
		.item_out (q_out)
	);

	tcs_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.cs      (slope_cos_sq_q),
		.q_empty (q_empty),
		.q_item  (q_out),
		.q_pop   (q_pop),
		.pop     (pop),
		.empty   (empty),
		.res     (res)
	);

	assign verdict  = res.verdict;
	assign walkable = res.walkable;

	a_walk_only_kept: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && walkable) |-> (verdict == VERDICT_KEPT))
		else $error("walkable result with a reject verdict");

	a_issue_needs_item: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> !q_empty)
		else $error("back issued from an empty queue");

	a_push_fills: assert property (@(posedge clk) disable iff (!arst_n)
		q_push |=> !q_empty)
		else $error("queue empty after a push");

endmodule
